>>> rtl/core/sliding_window_min_max_mean_defines.svh
// ----------------------------------------------------------------------------
// Sliding window min/max/mean - assertion macros
// Concurrent assertion helpers shared by the core modules. They reduce to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define SWMM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("swmm assertion failed (same-cycle implication)");

// Check that cons holds in the cycle after ante
`define SWMM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("swmm assertion failed (next-cycle implication)");

`else

`define SWMM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SWMM_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/core/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants and types for the sliding window min/max/mean core.
// ----------------------------------------------------------------------------
package swmm_pkg;

    // Sample and result width (signed Q16.16)
    localparam int DATA_W         = 32;
    // Width of the fill count result field
    localparam int FILL_OUT_W     = 3;
    // Number of window entries shown on the result ports
    localparam int SHOWN_ENTRIES  = 5;
    // Default window length
    localparam int WINDOW_LEN_DEF = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } swmm_state_t;

endpackage

>>> rtl/core/swmm_scan.sv
// ----------------------------------------------------------------------------
// swmm_scan
// Walks the filled window entries one per cycle through a single
// compare/accumulate step, building maximum, minimum and exact sum.
// ----------------------------------------------------------------------------
module swmm_scan
    import swmm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int CNT_W      = $clog2(WINDOW_LEN + 1),
    parameter int IDX_W      = $clog2(WINDOW_LEN),
    parameter int SUM_W      = DATA_W + IDX_W
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [DATA_W-1:0] entry,
    output logic [IDX_W-1:0]        idx,
    output logic                    done,
    output logic signed [DATA_W-1:0] max_val,
    output logic signed [DATA_W-1:0] min_val,
    output logic signed [SUM_W-1:0] sum_val
);

    logic                     busy_reg;
    logic                     first_reg;
    logic                     done_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  entry_ext;
    logic                     last;

    assign entry_ext = {{(SUM_W - DATA_W){entry[DATA_W-1]}}, entry};
    assign last      = (CNT_W'(idx_reg) == (count - CNT_W'(1)));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                idx_reg   <= '0;
            end
            else if (busy_reg)
            begin
                first_reg <= 1'b0;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Shared compare/accumulate step
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (first_reg)
            begin
                max_reg <= entry;
                min_reg <= entry;
                sum_reg <= entry_ext;
            end
            else
            begin
                if (entry > max_reg)
                begin
                    max_reg <= entry;
                end
                if (entry < min_reg)
                begin
                    min_reg <= entry;
                end
                sum_reg <= sum_reg + entry_ext;
            end
        end
    end

    assign idx     = idx_reg;
    assign done    = done_reg;
    assign max_val = max_reg;
    assign min_val = min_reg;
    assign sum_val = sum_reg;

endmodule

>>> rtl/core/swmm_div.sv
// ----------------------------------------------------------------------------
// swmm_div
// Restoring serial divider, one quotient bit per cycle. Divides a signed
// sum by an unsigned count, truncating toward zero.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_mean_defines.svh"

module swmm_div
    import swmm_pkg::*;
#(
    parameter int SUM_W = DATA_W + 3,
    parameter int CNT_W = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int BIT_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [BIT_W-1:0]  bits_reg;
    logic              neg_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [SUM_W-1:0]  magnitude;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [SUM_W-1:0]  signed_quo;

    assign magnitude  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
    assign shifted    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial      = shifted - {1'b0, div_reg};
    assign fits       = !trial[CNT_W];
    assign signed_quo = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bits_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bits_reg <= BIT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                bits_reg <= bits_reg - BIT_W'(1);
                if (bits_reg == BIT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= magnitude;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit, subtract if it fits
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = signed_quo[DATA_W-1:0];

    `SWMM_ASSERT_IMP(a_div_bits_live, clk, rst_n, busy_reg, bits_reg != '0)

endmodule

>>> rtl/core/sliding_window_min_max_mean.sv
// ----------------------------------------------------------------------------
// Sliding window min/max/mean
// Keeps the last WINDOW_LEN Q16.16 samples and reports max, min, mean,
// fill count and the window contents for every sample.
// ----------------------------------------------------------------------------
// One sample in, one result out. On acceptance the sample enters the
// window (appended while filling, shifted in once full), then a scan unit
// walks the filled entries one per cycle for max, min and exact sum, and a
// serial divider produces the mean one quotient bit per cycle, truncating
// toward zero. Most of the time from acceptance to a valid result is spent
// in the divider. The next sample is taken at the earliest in the cycle
// after the result transaction. in_stall stays high from acceptance until
// the result transaction completes, so the block works on one sample at a
// time. Entries at or beyond the fill count read as zero; with a window
// longer than five, only the five oldest entries are shown and fill_count
// carries the low three bits of the count.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_mean_defines.svh"

module sliding_window_min_max_mean
    import swmm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] sample,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] win_max,
    output logic signed [DATA_W-1:0] win_min,
    output logic signed [DATA_W-1:0] win_mean,
    output logic [FILL_OUT_W-1:0]    fill_count,
    output logic signed [DATA_W-1:0] entry0,
    output logic signed [DATA_W-1:0] entry1,
    output logic signed [DATA_W-1:0] entry2,
    output logic signed [DATA_W-1:0] entry3,
    output logic signed [DATA_W-1:0] entry4
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int IDX_W = $clog2(WINDOW_LEN);
    // Sum of WINDOW_LEN samples needs IDX_W guard bits
    localparam int SUM_W = DATA_W + IDX_W;

    swmm_state_t state_reg;
    swmm_state_t state_next;

    logic signed [DATA_W-1:0] window_reg  [WINDOW_LEN];
    logic signed [DATA_W-1:0] window_next [WINDOW_LEN];
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     full;
    logic                     in_accept;

    logic                     scan_start;
    logic                     scan_done;
    logic [IDX_W-1:0]         scan_idx;
    logic signed [DATA_W-1:0] scan_max;
    logic signed [DATA_W-1:0] scan_min;
    logic signed [SUM_W-1:0]  scan_sum;

    logic                     div_start;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quo;

    logic signed [DATA_W-1:0] shown [SHOWN_ENTRIES];
    logic [CNT_W+2:0]         fill_wide;

    assign full      = (fill_reg == CNT_W'(WINDOW_LEN));
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Window store: append while filling, shift toward the oldest end
    // once full. Payload only, so no reset.
    // ------------------------------------------------------------------
    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (in_accept)
        begin
            if (full)
            begin
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                begin
                    window_next[i] = window_reg[i + 1];
                end
                window_next[WINDOW_LEN - 1] = sample;
            end
            else
            begin
                window_next[fill_reg[IDX_W-1:0]] = sample;
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            state_reg <= ST_IDLE;
        end
        else
        begin
            fill_reg  <= fill_next;
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: accept, scan the window, divide, present the result
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        scan_start = 1'b0;
        div_start  = 1'b0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    // Scan starts reading the updated window next cycle
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                // Hold the result until the transaction completes
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared scan unit and serial divider
    // ------------------------------------------------------------------
    swmm_scan #(
        .WINDOW_LEN (WINDOW_LEN),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W),
        .SUM_W      (SUM_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .count   (fill_reg),
        .entry   (window_reg[scan_idx]),
        .idx     (scan_idx),
        .done    (scan_done),
        .max_val (scan_max),
        .min_val (scan_min),
        .sum_val (scan_sum)
    );

    swmm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scan_sum),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Result fields: all come straight from registers that stay put
    // while the result is presented.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < SHOWN_ENTRIES; k++)
    begin : g_shown
        if (k < WINDOW_LEN)
        begin : g_live
            // Drop entries that are not yet filled
            assign shown[k] = (fill_reg > CNT_W'(k)) ? window_reg[k] : '0;
        end
        else
        begin : g_absent
            assign shown[k] = '0;
        end
    end

    assign fill_wide  = (CNT_W + 3)'(fill_reg);
    assign fill_count = fill_wide[FILL_OUT_W-1:0];

    assign win_max  = scan_max;
    assign win_min  = scan_min;
    assign win_mean = div_quo;
    assign entry0   = shown[0];
    assign entry1   = shown[1];
    assign entry2   = shown[2];
    assign entry3   = shown[3];
    assign entry4   = shown[4];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SWMM_ASSERT_NXT(a_accept_starts_scan, clk, rst_n, in_accept, state_reg == ST_SCAN)
    `SWMM_ASSERT_IMP(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= CNT_W'(WINDOW_LEN))
    `SWMM_ASSERT_IMP(a_result_has_entries, clk, rst_n, out_valid, fill_reg != '0)

endmodule
